@@ hw/rtl/satp_pkg.sv @@
package satp_pkg;

	// Fixed field widths of the access and result items.
	localparam int WORD_W = 32;
	localparam int OUT_WAY_W = 2;

	// Replacement state widths and saturation limits.
	localparam int AGE_W = 8;
	localparam int CNT_W = 16;
	localparam logic [AGE_W-1:0] AGE_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Default geometry.
	localparam int DEF_NUM_SETS = 64;
	localparam int DEF_NUM_WAYS = 4;
	localparam int DEF_BLOCK_BYTES = 64;
	localparam int DEF_ADDR_WIDTH = 32;

	// Replacement modes.
	typedef enum logic [1:0] {
		MODE_FIFO = 2'd0,
		MODE_LRU  = 2'd1,
		MODE_LFU  = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_REPL_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WT_MODE = 1'd1;

	// Access kinds.
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	// One result item.
	typedef struct packed {
		logic error;
		logic hit;
		logic [OUT_WAY_W-1:0] way;
		logic fetch_valid;
		logic [WORD_W-1:0] fetch_address;
		logic writeback_valid;
		logic [WORD_W-1:0] writeback_address;
		logic mem_write_valid;
		logic signed [WORD_W-1:0] mem_write_data;
	} rsp_t;

	// Configuration seen by the back end.
	typedef struct packed {
		mode_t mode;
		logic write_through;
	} cfg_t;

endpackage

@@ hw/rtl/satp_req_if.sv @@
interface satp_req_if;
	import satp_pkg::*;

	logic valid;
	logic ready;
	logic kind;
	logic [WORD_W-1:0] address;
	logic signed [WORD_W-1:0] write_data;

	modport source (output valid, kind, address, write_data, input ready);
	modport sink (input valid, kind, address, write_data, output ready);
endinterface

@@ hw/rtl/satp_rsp_if.sv @@
interface satp_rsp_if;
	import satp_pkg::*;

	logic valid;
	logic ready;
	logic error;
	logic hit;
	logic [OUT_WAY_W-1:0] way;
	logic fetch_valid;
	logic [WORD_W-1:0] fetch_address;
	logic writeback_valid;
	logic [WORD_W-1:0] writeback_address;
	logic mem_write_valid;
	logic signed [WORD_W-1:0] mem_write_data;

	modport source (output valid, error, hit, way, fetch_valid, fetch_address,
		writeback_valid, writeback_address, mem_write_valid, mem_write_data,
		input ready);
	modport sink (input valid, error, hit, way, fetch_valid, fetch_address,
		writeback_valid, writeback_address, mem_write_valid, mem_write_data,
		output ready);
endinterface

@@ hw/rtl/set_assoc_cache_tag_policy_unit.sv @@
// Tag and replacement engine of a set-associative cache. Each request is one
// word access; the front end splits its address and flags a misaligned word,
// a two-entry queue holds it, and the back end reads the set's tags and policy
// state from a one-port set memory, then decides hit, fill or eviction (FIFO,
// LRU or LFU, else way 0) and writes the set back once the output register is
// free; it takes no new request until then. The user must write configuration
// only while idle; the block itself does not enforce it.
module set_assoc_cache_tag_policy_unit
	import satp_pkg::*;
#(
	parameter int NUM_SETS = DEF_NUM_SETS,
	parameter int NUM_WAYS = DEF_NUM_WAYS,
	parameter int BLOCK_BYTES = DEF_BLOCK_BYTES,
	parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [satp_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [satp_pkg::CFG_DATA_W-1:0] cfg_data,
	satp_req_if.sink req,
	satp_rsp_if.source rsp
);
	localparam int OFF_W = $clog2(BLOCK_BYTES);
	localparam int SET_W = $clog2(NUM_SETS);
	localparam int SET_IW = (SET_W > 0) ? SET_W : 1;
	localparam int TAG_W = ADDR_WIDTH - OFF_W - SET_W;
	localparam int ENT_W = 2 + TAG_W + SET_IW + WORD_W;

	cfg_t cfg_q;
	logic push_valid;
	logic push_ready;
	logic [ENT_W-1:0] push_ent;
	logic pop_valid;
	logic pop_ready;
	logic [ENT_W-1:0] pop_ent;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= MODE_LRU;
			cfg_q.write_through <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_REPL_MODE: cfg_q.mode <= mode_t'(cfg_data);
				CFG_WT_MODE: cfg_q.write_through <= cfg_data[0];
				default: ;
			endcase
		end
	end

	satp_front #(
		.NUM_SETS(NUM_SETS), .BLOCK_BYTES(BLOCK_BYTES), .ADDR_WIDTH(ADDR_WIDTH),
		.TAG_W(TAG_W), .SET_IW(SET_IW), .ENT_W(ENT_W)
	) u_front (
		.req(req), .push_valid(push_valid), .push_ready(push_ready),
		.push_ent(push_ent)
	);

	satp_queue #(.W(ENT_W)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(push_valid), .push_ready(push_ready), .push_data(push_ent),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_ent)
	);

	satp_back #(
		.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .BLOCK_BYTES(BLOCK_BYTES),
		.ADDR_WIDTH(ADDR_WIDTH), .TAG_W(TAG_W), .SET_IW(SET_IW), .ENT_W(ENT_W)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop_ent(pop_ent),
		.rsp(rsp)
	);
endmodule

@@ hw/rtl/satp_front.sv @@
module satp_front #(
	parameter int NUM_SETS = 64,
	parameter int BLOCK_BYTES = 64,
	parameter int ADDR_WIDTH = 32,
	parameter int TAG_W = 20,
	parameter int SET_IW = 6,
	parameter int ENT_W = 60
) (
	satp_req_if.sink req,
	output logic push_valid,
	input logic push_ready,
	output logic [ENT_W-1:0] push_ent
);
	import satp_pkg::*;

	localparam int OFF_W = $clog2(BLOCK_BYTES);
	localparam int SET_W = $clog2(NUM_SETS);

	typedef struct packed {
		logic err;
		logic kind;
		logic [TAG_W-1:0] tag;
		logic [SET_IW-1:0] set;
		logic signed [WORD_W-1:0] wdata;
	} entry_t;

	logic [ADDR_WIDTH-1:0] addr_cut;
	entry_t ent;

	// Split the address and flag an access that is not word aligned.
	always_comb begin
		addr_cut = ADDR_WIDTH'(req.address);
		ent.err = |req.address[1:0];
		ent.kind = req.kind;
		ent.tag = TAG_W'(addr_cut >> (OFF_W + SET_W));
		ent.set = SET_IW'((addr_cut >> OFF_W) & ADDR_WIDTH'(NUM_SETS - 1));
		ent.wdata = req.write_data;
	end

	assign push_ent = ent;
	assign push_valid = req.valid;
	assign req.ready = push_ready;
endmodule

@@ hw/rtl/satp_queue.sv @@
module satp_queue #(
	parameter int W = 60
) (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input logic [W-1:0] push_data,
	output logic pop_valid,
	input logic pop_ready,
	output logic [W-1:0] pop_data
);
	// Two-entry ring buffer.
	logic [W-1:0] slot_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_data = slot_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	// Pointer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

	// Payload storage.
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_data;
	end
endmodule

@@ hw/rtl/satp_back.sv @@
module satp_back #(
	parameter int NUM_SETS = 64,
	parameter int NUM_WAYS = 4,
	parameter int BLOCK_BYTES = 64,
	parameter int ADDR_WIDTH = 32,
	parameter int TAG_W = 20,
	parameter int SET_IW = 6,
	parameter int ENT_W = 60
) (
	input logic clk,
	input logic arst_n,
	input satp_pkg::cfg_t cfg,
	input logic pop_valid,
	output logic pop_ready,
	input logic [ENT_W-1:0] pop_ent,
	satp_rsp_if.source rsp
);
	import satp_pkg::*;

	localparam int OFF_W = $clog2(BLOCK_BYTES);
	localparam int SET_W = $clog2(NUM_SETS);
	localparam int WAY_W = $clog2(NUM_WAYS);
	localparam int WAY_IW = (WAY_W > 0) ? WAY_W : 1;

	typedef struct packed {
		logic err;
		logic kind;
		logic [TAG_W-1:0] tag;
		logic [SET_IW-1:0] set;
		logic signed [WORD_W-1:0] wdata;
	} entry_t;

	// One set of the tag and policy memory.
	typedef struct packed {
		logic [NUM_WAYS-1:0][TAG_W-1:0] tag;
		logic [NUM_WAYS-1:0] dirty;
		logic [NUM_WAYS-1:0][AGE_W-1:0] age;
		logic [NUM_WAYS-1:0][CNT_W-1:0] cnt;
		logic [WAY_IW-1:0] fifo;
	} row_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	row_t set_mem [NUM_SETS];
	row_t row_s1;
	entry_t cur_s1;
	logic [NUM_WAYS-1:0] line_vld_q [NUM_SETS];
	logic [NUM_SETS-1:0] row_vld_q;
	rsp_t out_q;
	logic out_vld_q;

	entry_t head;
	logic [NUM_WAYS-1:0] vld_cur;
	logic [WAY_IW-1:0] fifo_cur;
	logic out_free;
	logic commit;
	row_t row_new;
	rsp_t res;
	logic [WAY_IW-1:0] w_sel;
	logic miss_fill;

	assign head = pop_ent;
	assign out_free = !out_vld_q || rsp.ready;
	assign commit = (state_q == ST_EXEC) && out_free;
	assign pop_ready = (state_q == ST_IDLE);
	assign vld_cur = line_vld_q[cur_s1.set];
	assign fifo_cur = row_vld_q[cur_s1.set] ? row_s1.fifo : '0;

	// Lookup, victim choice and policy update on the registered row read in the idle state.
	always_comb begin
		logic hit;
		logic [WAY_IW-1:0] hit_w;
		logic any_free;
		logic [WAY_IW-1:0] free_w;
		logic [WAY_IW-1:0] vic_w;
		logic [AGE_W:0] best_age;
		logic [CNT_W:0] best_cnt;
		logic evict;
		logic [ADDR_WIDTH-1:0] blk_addr;
		logic [ADDR_WIDTH-1:0] vic_addr;

		hit = 1'b0;
		hit_w = '0;
		any_free = 1'b0;
		free_w = '0;
		vic_w = '0;
		best_age = '1;
		best_cnt = '1;
		row_new = row_s1;
		row_new.fifo = fifo_cur;
		res = '0;

		for (int i = NUM_WAYS - 1; i >= 0; i--) begin
			if (vld_cur[i] && row_s1.tag[i] == cur_s1.tag) begin
				hit = 1'b1;
				hit_w = WAY_IW'(i);
			end
			if (!vld_cur[i]) begin
				any_free = 1'b1;
				free_w = WAY_IW'(i);
			end
		end

		// Victim search over a full set.
		unique case (cfg.mode)
			MODE_FIFO: vic_w = fifo_cur;
			MODE_LRU: begin
				best_age = '1;
				for (int i = 0; i < NUM_WAYS; i++) begin
					if (best_age == '1 || {1'b0, row_s1.age[i]} > best_age) begin
						best_age = {1'b0, row_s1.age[i]};
						vic_w = WAY_IW'(i);
					end
				end
			end
			MODE_LFU: begin
				for (int i = 0; i < NUM_WAYS; i++) begin
					if ({1'b0, row_s1.cnt[i]} < best_cnt) begin
						best_cnt = {1'b0, row_s1.cnt[i]};
						vic_w = WAY_IW'(i);
					end
				end
			end
			default: vic_w = '0;
		endcase

		evict = !hit && !any_free;
		w_sel = hit ? hit_w : (any_free ? free_w : vic_w);
		miss_fill = !hit;

		blk_addr = (ADDR_WIDTH'(cur_s1.tag) << (OFF_W + SET_W))
			| (ADDR_WIDTH'(cur_s1.set) << OFF_W);
		vic_addr = (ADDR_WIDTH'(row_s1.tag[vic_w]) << (OFF_W + SET_W))
			| (ADDR_WIDTH'(cur_s1.set) << OFF_W);

		if (evict && cfg.mode == MODE_FIFO) begin
			row_new.fifo = (vic_w == WAY_IW'(NUM_WAYS - 1)) ? '0 : vic_w + 1'b1;
		end
		if (evict && row_s1.dirty[vic_w] && !cfg.write_through) begin
			res.writeback_valid = 1'b1;
			res.writeback_address = WORD_W'(vic_addr);
		end

		// Fill the chosen way.
		if (!hit) begin
			row_new.tag[w_sel] = cur_s1.tag;
			row_new.dirty[w_sel] = 1'b0;
			row_new.cnt[w_sel] = CNT_W'(1);
			row_new.age[w_sel] = AGE_W'(1);
			res.fetch_valid = 1'b1;
			res.fetch_address = WORD_W'(blk_addr);
		end

		// Recency or frequency update.
		if (cfg.mode == MODE_LRU) begin
			for (int i = 0; i < NUM_WAYS; i++) begin
				if (WAY_IW'(i) == w_sel) begin
					row_new.age[i] = AGE_W'(1);
				end else if (vld_cur[i] && row_s1.age[i] != AGE_MAX) begin
					row_new.age[i] = row_s1.age[i] + 1'b1;
				end
			end
		end else if (cfg.mode == MODE_LFU && hit && row_s1.cnt[w_sel] != CNT_MAX) begin
			row_new.cnt[w_sel] = row_s1.cnt[w_sel] + 1'b1;
		end

		// Write handling.
		if (cur_s1.kind == KIND_WRITE) begin
			if (cfg.write_through) begin
				res.mem_write_valid = 1'b1;
				res.mem_write_data = cur_s1.wdata;
			end else begin
				row_new.dirty[w_sel] = 1'b1;
			end
		end
		res.hit = hit;
		res.way = OUT_WAY_W'(w_sel);

		if (cur_s1.err) begin
			res = '0;
			res.error = 1'b1;
		end
	end

	// Sequencer, output register and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_vld_q <= 1'b0;
			row_vld_q <= '0;
			for (int s = 0; s < NUM_SETS; s++) line_vld_q[s] <= '0;
		end else begin
			if (commit) out_vld_q <= 1'b1;
			else if (rsp.ready) out_vld_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (commit) begin
						state_q <= ST_IDLE;
						if (!cur_s1.err) begin
							row_vld_q[cur_s1.set] <= 1'b1;
							if (miss_fill) line_vld_q[cur_s1.set][w_sel] <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Set memory with registered read, and payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop_valid) begin
			row_s1 <= set_mem[head.set];
			cur_s1 <= head;
		end
		if (commit && !cur_s1.err) set_mem[cur_s1.set] <= row_new;
		if (commit) out_q <= res;
	end

	assign rsp.valid = out_vld_q;
	assign rsp.error = out_q.error;
	assign rsp.hit = out_q.hit;
	assign rsp.way = out_q.way;
	assign rsp.fetch_valid = out_q.fetch_valid;
	assign rsp.fetch_address = out_q.fetch_address;
	assign rsp.writeback_valid = out_q.writeback_valid;
	assign rsp.writeback_address = out_q.writeback_address;
	assign rsp.mem_write_valid = out_q.mem_write_valid;
	assign rsp.mem_write_data = out_q.mem_write_data;
endmodule
